// ===== rtl/dqsd_pkg.sv =====
`timescale 1ns / 1ps

package dqsd_pkg;

    localparam int FFT_SIZE  = 2048;
    localparam int ADDR_W    = $clog2(FFT_SIZE);
    localparam int BIN_W     = 11;
    localparam int CARR_W    = 11;
    localparam int SAMP_W    = 16;
    localparam int SOFT_W    = 8;
    localparam int IDX_EXT_W = (ADDR_W > BIN_W) ? ADDR_W : BIN_W;
    localparam int REF_W     = 2 * SAMP_W;
    localparam int PROD_W    = 2 * SAMP_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int MAG_W     = PROD_W;
    localparam int NORM_W    = MAG_W + 1;
    localparam int Q_W       = 7;
    localparam int NUM_W     = NORM_W + Q_W;
    localparam int DIV_STEPS = Q_W;

    typedef enum logic {
        CMD_REF  = 1'b0,
        CMD_DATA = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                     command;
        logic [BIN_W-1:0]         bin_index;
        logic [CARR_W-1:0]        carrier_number;
        logic signed [SAMP_W-1:0] sample_re;
        logic signed [SAMP_W-1:0] sample_im;
    } t_in_item;

    typedef struct packed {
        logic signed [SOFT_W-1:0] soft_first;
        logic signed [SOFT_W-1:0] soft_second;
        logic [CARR_W-1:0]        carrier_slot;
    } t_out_item;

    typedef struct packed {
        logic [CARR_W-1:0]        carrier;
        logic signed [SAMP_W-1:0] x_re;
        logic signed [SAMP_W-1:0] x_im;
        logic signed [SAMP_W-1:0] r_re;
        logic signed [SAMP_W-1:0] r_im;
    } t_mul_in;

    typedef struct packed {
        logic [CARR_W-1:0] carrier;
        logic [NORM_W-1:0] norm;
        logic [NUM_W-1:0]  num_f;
        logic [NUM_W-1:0]  num_s;
        logic              neg_f;
        logic              neg_s;
    } t_div_in;

    typedef struct packed {
        logic [CARR_W-1:0] carrier;
        logic [NORM_W-1:0] norm;
        logic [NUM_W-1:0]  rem_f;
        logic [NUM_W-1:0]  rem_s;
        logic [Q_W-1:0]    q_f;
        logic [Q_W-1:0]    q_s;
        logic              neg_f;
        logic              neg_s;
    } t_div_stage;

endpackage

// ===== rtl/dqsd_ref_store.sv =====
`timescale 1ns / 1ps

module dqsd_ref_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [dqsd_pkg::ADDR_W-1:0] i_addr,
    input  logic [dqsd_pkg::REF_W-1:0]  i_wdata,
    output logic [dqsd_pkg::REF_W-1:0]  o_rdata,
    output logic                       o_busy
);
    import dqsd_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(FFT_SIZE - 1);

    logic [REF_W-1:0]  r_mem [FFT_SIZE];
    logic [REF_W-1:0]  r_rdata;
    logic              r_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              w_wen;
    logic [ADDR_W-1:0] w_waddr;
    logic [REF_W-1:0]  w_wdata;

    assign w_wen   = r_busy || i_we;
    assign w_waddr = r_busy ? r_clr_addr : i_addr;
    assign w_wdata = r_busy ? '0 : i_wdata;

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_we) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

    a_no_write_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> !i_we
    ) else $error("port write during clearing pass");

endmodule

// ===== rtl/dqsd_cmul.sv =====
`timescale 1ns / 1ps

module dqsd_cmul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dqsd_pkg::t_mul_in i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output dqsd_pkg::t_div_in o_data
);
    import dqsd_pkg::*;

    logic r_v_prod, r_v_sum, r_v_mag, r_v_norm;
    logic w_en_prod, w_en_sum, w_en_mag, w_en_norm;

    logic [CARR_W-1:0]        r_prod_carrier;
    logic signed [PROD_W-1:0] r_p_rr, r_p_ii, r_p_ir, r_p_ri;
    logic signed [PROD_W-1:0] n_p_rr, n_p_ii, n_p_ir, n_p_ri;

    logic [CARR_W-1:0]        r_sum_carrier;
    logic signed [SUM_W-1:0]  r_pr, r_pi;
    logic signed [SUM_W-1:0]  n_pr, n_pi;

    logic [CARR_W-1:0]        r_mag_carrier;
    logic [MAG_W-1:0]         r_mag_f, r_mag_s;
    logic [MAG_W-1:0]         n_mag_f, n_mag_s;
    logic                     r_neg_f, r_neg_s;

    t_div_in                  r_out;
    t_div_in                  n_out;

    assign w_en_norm = !r_v_norm || i_ready;
    assign w_en_mag  = !r_v_mag  || w_en_norm;
    assign w_en_sum  = !r_v_sum  || w_en_mag;
    assign w_en_prod = !r_v_prod || w_en_sum;

    assign n_p_rr = i_data.x_re * i_data.r_re;
    assign n_p_ii = i_data.x_im * i_data.r_im;
    assign n_p_ir = i_data.x_im * i_data.r_re;
    assign n_p_ri = i_data.x_re * i_data.r_im;

    assign n_pr = SUM_W'(r_p_rr) + SUM_W'(r_p_ii);
    assign n_pi = SUM_W'(r_p_ir) - SUM_W'(r_p_ri);

    assign n_mag_f = r_pr[SUM_W-1] ? MAG_W'(-r_pr) : MAG_W'(r_pr);
    assign n_mag_s = r_pi[SUM_W-1] ? MAG_W'(-r_pi) : MAG_W'(r_pi);

    always_comb begin
        n_out.carrier = r_mag_carrier;
        n_out.norm    = NORM_W'(r_mag_f) + NORM_W'(r_mag_s);
        n_out.num_f   = (NUM_W'(r_mag_f) << Q_W) - NUM_W'(r_mag_f);
        n_out.num_s   = (NUM_W'(r_mag_s) << Q_W) - NUM_W'(r_mag_s);
        n_out.neg_f   = r_neg_f;
        n_out.neg_s   = r_neg_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_prod <= 1'b0;
            r_v_sum  <= 1'b0;
            r_v_mag  <= 1'b0;
            r_v_norm <= 1'b0;
        end else begin
            if (w_en_prod) begin
                r_v_prod <= i_valid;
            end
            if (w_en_sum) begin
                r_v_sum <= r_v_prod;
            end
            if (w_en_mag) begin
                r_v_mag <= r_v_sum;
            end
            if (w_en_norm) begin
                r_v_norm <= r_v_mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_prod && i_valid) begin
            r_prod_carrier <= i_data.carrier;
            r_p_rr         <= n_p_rr;
            r_p_ii         <= n_p_ii;
            r_p_ir         <= n_p_ir;
            r_p_ri         <= n_p_ri;
        end
        if (w_en_sum && r_v_prod) begin
            r_sum_carrier <= r_prod_carrier;
            r_pr          <= n_pr;
            r_pi          <= n_pi;
        end
        if (w_en_mag && r_v_sum) begin
            r_mag_carrier <= r_sum_carrier;
            r_mag_f       <= n_mag_f;
            r_mag_s       <= n_mag_s;
            r_neg_f       <= r_pr[SUM_W-1];
            r_neg_s       <= r_pi[SUM_W-1];
        end
        if (w_en_norm && r_v_mag) begin
            r_out <= n_out;
        end
    end

    assign o_ready = w_en_prod;
    assign o_valid = r_v_norm;
    assign o_data  = r_out;

endmodule

// ===== rtl/dqsd_div.sv =====
`timescale 1ns / 1ps

module dqsd_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dqsd_pkg::t_div_in   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output dqsd_pkg::t_out_item o_item
);
    import dqsd_pkg::*;

    logic       r_v [DIV_STEPS+1];
    logic       w_en [DIV_STEPS+1];
    logic       w_vin [DIV_STEPS+1];
    t_div_stage r_st [DIV_STEPS];
    t_div_stage w_src [DIV_STEPS];
    t_div_stage n_st [DIV_STEPS];
    t_out_item  r_out;
    t_out_item  n_out;
    t_div_stage w_last;
    logic       w_zero;

    always_comb begin
        w_en[DIV_STEPS] = !r_v[DIV_STEPS] || i_ready;
        for (int k = DIV_STEPS - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign w_vin[0] = i_valid;
    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_vin
        assign w_vin[j] = r_v[j-1];
    end

    always_comb begin
        w_src[0].carrier = i_data.carrier;
        w_src[0].norm    = i_data.norm;
        w_src[0].rem_f   = i_data.num_f;
        w_src[0].rem_s   = i_data.num_s;
        w_src[0].q_f     = '0;
        w_src[0].q_s     = '0;
        w_src[0].neg_f   = i_data.neg_f;
        w_src[0].neg_s   = i_data.neg_s;
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        localparam int SH = DIV_STEPS - 1 - j;
        logic [NUM_W-1:0] w_dsh;

        if (j > 0) begin : g_link
            assign w_src[j] = r_st[j-1];
        end

        assign w_dsh = NUM_W'(w_src[j].norm) << SH;

        always_comb begin
            n_st[j] = w_src[j];
            if (w_src[j].rem_f >= w_dsh) begin
                n_st[j].rem_f  = w_src[j].rem_f - w_dsh;
                n_st[j].q_f[SH] = 1'b1;
            end
            if (w_src[j].rem_s >= w_dsh) begin
                n_st[j].rem_s  = w_src[j].rem_s - w_dsh;
                n_st[j].q_s[SH] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[j] && w_vin[j]) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    assign w_last = r_st[DIV_STEPS-1];
    assign w_zero = (w_last.norm == '0);

    always_comb begin
        n_out.carrier_slot = w_last.carrier;
        if (w_zero) begin
            n_out.soft_first  = '0;
            n_out.soft_second = '0;
        end else begin
            n_out.soft_first  = w_last.neg_f ? SOFT_W'(w_last.q_f)
                                             : SOFT_W'(-SOFT_W'(w_last.q_f));
            n_out.soft_second = w_last.neg_s ? SOFT_W'(w_last.q_s)
                                             : SOFT_W'(-SOFT_W'(w_last.q_s));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= w_vin[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[DIV_STEPS] && w_vin[DIV_STEPS]) begin
            r_out <= n_out;
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[DIV_STEPS];
    assign o_item  = r_out;

    a_soft_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.soft_first != -8'sd128 && o_item.soft_second != -8'sd128)
    ) else $error("soft bit out of range");

    a_zero_norm_gives_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v[DIV_STEPS-1] && w_en[DIV_STEPS] && w_zero)
            |=> (o_item.soft_first == '0 && o_item.soft_second == '0)
    ) else $error("zero norm did not give zero soft bits");

endmodule

// ===== rtl/differential_qpsk_soft_demod_top.sv =====
`timescale 1ns / 1ps
// Differential QPSK soft demodulator.
// Input channel (i_valid / o_ready, i_item): one carrier bin per transaction with
// its bin index and a command. A reference command stores the bin as that bin's
// phase reference and produces nothing. A data command multiplies the bin by the
// conjugate of the stored reference, replaces the reference, and produces one
// transaction on the output channel (o_valid / i_ready, o_item) carrying two
// soft bits and the carrier number.
// Throughput: one transaction per cycle while o_ready is high. The reference store
// is a single-port read-first RAM that reads the old reference and writes the new
// one on the same edge, so back-to-back bins at the same index need no forwarding.
// Pipeline: the edge that accepts an input loads the RAM read and the input
// register; 4 multiply/norm stages, 7 divide stages and 1 output register
// follow, and the output register drives o_valid.
// Reset: the reference store is cleared by a sweep over all 2048 entries; o_ready
// stays low during the sweep.
// Stall: when i_ready is low the output holds; bubbles in the pipeline still
// close up, and o_ready drops only once every stage holds a result.

module differential_qpsk_soft_demod_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dqsd_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output dqsd_pkg::t_out_item o_item
);
    import dqsd_pkg::*;

    logic                     w_accept;
    logic                     w_busy;
    logic                     w_cmul_ready;
    logic                     w_div_ready;
    logic                     w_cmul_valid;
    logic [IDX_EXT_W-1:0]     w_bin_ext;
    logic [ADDR_W-1:0]        w_addr;
    logic [REF_W-1:0]         w_ref;
    t_mul_in                  w_mul_in;
    t_div_in                  w_div_in;

    logic                     r_s1_valid;
    logic [CARR_W-1:0]        r_s1_carrier;
    logic signed [SAMP_W-1:0] r_s1_re;
    logic signed [SAMP_W-1:0] r_s1_im;

    assign o_ready   = !w_busy && (!r_s1_valid || w_cmul_ready);
    assign w_accept  = i_valid && o_ready;
    assign w_bin_ext = IDX_EXT_W'(i_item.bin_index);
    assign w_addr    = w_bin_ext[ADDR_W-1:0];

    dqsd_ref_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_accept),
        .i_addr  (w_addr),
        .i_wdata ({i_item.sample_re, i_item.sample_im}),
        .o_rdata (w_ref),
        .o_busy  (w_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!r_s1_valid || w_cmul_ready) begin
            r_s1_valid <= w_accept && (i_item.command == CMD_DATA);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_carrier <= i_item.carrier_number;
            r_s1_re      <= i_item.sample_re;
            r_s1_im      <= i_item.sample_im;
        end
    end

    always_comb begin
        w_mul_in.carrier = r_s1_carrier;
        w_mul_in.x_re    = r_s1_re;
        w_mul_in.x_im    = r_s1_im;
        w_mul_in.r_re    = w_ref[REF_W-1:SAMP_W];
        w_mul_in.r_im    = w_ref[SAMP_W-1:0];
    end

    dqsd_cmul u_cmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .o_ready (w_cmul_ready),
        .i_data  (w_mul_in),
        .o_valid (w_cmul_valid),
        .i_ready (w_div_ready),
        .o_data  (w_div_in)
    );

    dqsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cmul_valid),
        .o_ready (w_div_ready),
        .i_data  (w_div_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    a_data_enters_pipe: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.command == CMD_DATA) |=> r_s1_valid
    ) else $error("accepted data transaction did not enter the pipeline");

    a_ref_makes_no_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.command == CMD_REF && w_cmul_ready) |=> !r_s1_valid
    ) else $error("reference transaction entered the pipeline");

endmodule
